// File: hw/rtl/boot_info_memory_map_parser_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the boot info memory map parser
// Concurrent checks that vanish when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef BOOT_INFO_MEMORY_MAP_PARSER_ASSERT_SVH
`define BOOT_INFO_MEMORY_MAP_PARSER_ASSERT_SVH

`ifndef SYNTHESIS
// expr must hold at every clock edge outside reset
`define BIMP_ASSERT_ALWAYS(lbl, clk, rstn, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) else $error(msg);
// ante implies cons in the same cycle
`define BIMP_ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error(msg);
`else
`define BIMP_ASSERT_ALWAYS(lbl, clk, rstn, expr, msg)
`define BIMP_ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

// File: hw/rtl/bimp_pkg.sv
// ----------------------------------------------------------------------------
// bimp_pkg
// Shared widths, codes and types of the boot info memory map parser.
// ----------------------------------------------------------------------------
package bimp_pkg;

	localparam int WORD_W  = 32;
	localparam int ADDR_W  = 64;
	localparam int IDX_W   = 6;
	localparam int TOTAL_W = 7;

	localparam int REGION_LIMIT = 64;

	// tag layout
	localparam logic [31:0] TAG_TYPE_END  = 32'd0;
	localparam logic [31:0] TAG_TYPE_MMAP = 32'd6;
	localparam int HDR_BYTES      = 8;
	localparam int MMAP_HDR_BYTES = 16;
	localparam int ENTRY_BYTES    = 20;
	localparam int ALIGN_BYTES    = 8;

	// output queue
	localparam int QUEUE_DEPTH = 8;
	localparam int QUEUE_AW    = 3;
	localparam int QUEUE_CW    = 4;

	typedef enum logic [1:0] {
		KIND_REGION   = 2'd0,
		KIND_END_TAG  = 2'd1,
		KIND_BLOB_END = 2'd2
	} kind_t;

	typedef struct packed {
		kind_t               kind;
		logic [ADDR_W-1:0]   base;
		logic [ADDR_W-1:0]   length;
		logic [WORD_W-1:0]   rtype;
		logic [IDX_W-1:0]    index;
		logic [TOTAL_W-1:0]  total;
		logic                last;
	} result_t;

endpackage

// File: hw/rtl/bimp_in_if.sv
// ----------------------------------------------------------------------------
// bimp_in_if
// Blob word channel: valid/ready with one 32-bit word and a start mark.
// ----------------------------------------------------------------------------
interface bimp_in_if import bimp_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [WORD_W-1:0] data_word;
	logic              first_word;

	modport source (output valid, output data_word, output first_word, input ready);
	modport sink   (input valid, input data_word, input first_word, output ready);
endinterface

// File: hw/rtl/bimp_out_if.sv
// ----------------------------------------------------------------------------
// bimp_out_if
// Result channel: valid/ready with one region or end-of-parse record.
// ----------------------------------------------------------------------------
interface bimp_out_if import bimp_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [1:0]         result_kind;
	logic [ADDR_W-1:0]  region_base;
	logic [ADDR_W-1:0]  region_length;
	logic [WORD_W-1:0]  region_type;
	logic [IDX_W-1:0]   region_index;
	logic [TOTAL_W-1:0] region_total;
	logic               last_result;

	modport source (output valid, output result_kind, output region_base,
		output region_length, output region_type, output region_index,
		output region_total, output last_result, input ready);
	modport sink   (input valid, input result_kind, input region_base,
		input region_length, input region_type, input region_index,
		input region_total, input last_result, output ready);
endinterface

// File: hw/rtl/boot_info_memory_map_parser.sv
// ----------------------------------------------------------------------------
// boot_info_memory_map_parser
// Walks a boot information blob word by word and reports memory map regions.
// ----------------------------------------------------------------------------
//
//  channel  dir  payload                                   requests
//  -------  ---  ----------------------------------------  ------------------
//  blob     in   data_word, first_word                     one blob word each
//  result   out  result_kind, region_base/length/type,     one record each,
//                region_index, region_total, last_result   0..2 per word
//
//  Cycles: one blob word per cycle while blob.ready is high. A word is registered
//  at s1, decoded the next cycle against the parse state, and its 0..2
//  records land in an 8-entry output queue; the first record is visible on
//  result once it has been written into the queue.
//  Stalls: blob.ready drops while more than four records wait in the queue,
//  which leaves room for the word in s1 and the one being accepted.
//  Reset: arst_n clears the parse state, s1 and the queue; no clearing pass.
//
// The parse itself is a one-hot phase machine. A tag header is type + size;
// a map tag (type 6) adds stride + version, then fixed 20-byte entries read at
// the stride, with any stride bytes past 20 skipped as padding. Tag ends are
// kept as byte positions and compared with the running word position.
// ----------------------------------------------------------------------------
`include "boot_info_memory_map_parser_assert.svh"

module boot_info_memory_map_parser import bimp_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	bimp_in_if.sink      blob,
	bimp_out_if.source   result
);

	typedef enum logic [13:0] {
		PH_IDLE       = 14'b00000000000001,
		PH_RSV        = 14'b00000000000010,
		PH_TYPE       = 14'b00000000000100,
		PH_SIZE_OTHER = 14'b00000000001000,
		PH_SIZE_MMAP  = 14'b00000000010000,
		PH_SKIP       = 14'b00000000100000,
		PH_STRIDE     = 14'b00000001000000,
		PH_VERSION    = 14'b00000010000000,
		PH_E0         = 14'b00000100000000,
		PH_E1         = 14'b00001000000000,
		PH_E2         = 14'b00010000000000,
		PH_E3         = 14'b00100000000000,
		PH_E4         = 14'b01000000000000,
		PH_EPAD       = 14'b10000000000000
	} phase_t;

	// ---------------- input register ----------------
	logic              s1_valid_s1;
	logic [WORD_W-1:0] s1_word_s1;
	logic              s1_first_s1;

	logic [QUEUE_CW-1:0] q_cnt_q;
	logic                blob_take;

	// Room for the word in s1 plus the one now accepted, two records each.
	assign blob.ready = (q_cnt_q <= QUEUE_CW'(QUEUE_DEPTH - 4));
	assign blob_take  = blob.valid && blob.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
		end else begin
			s1_valid_s1 <= blob_take;
		end
	end

	always_ff @(posedge clk) begin
		if (blob_take) begin
			s1_word_s1  <= blob.data_word;
			s1_first_s1 <= blob.first_word;
		end
	end

	// ---------------- parse state ----------------
	phase_t             phase_q, phase_d;
	logic [31:0]        pos_q, pos_d;          // byte position of next word
	logic [31:0]        blob_size_q, blob_size_d;
	logic [31:0]        tag_end_q, tag_end_d;
	logic [31:0]        stride_q, stride_d;
	logic [31:0]        ent_start_q, ent_start_d;
	logic [ADDR_W-1:0]  held_addr_q, held_addr_d;
	logic [ADDR_W-1:0]  held_len_q, held_len_d;
	logic [TOTAL_W-1:0] regions_q, regions_d;

	result_t    res_v [2];
	logic [1:0] push_n;

	// step-local terms
	logic [31:0] w;
	logic        c_neg;        // tag start below zero (position wrapped)
	logic [33:0] c_w;          // tag start
	logic [33:0] size_a;       // tag size rounded to 8, at least 8
	logic [33:0] map_end;
	logic        fin_req;
	logic        fin_ovf;
	logic [34:0] fin_next;     // start of the following tag
	logic        ent_chk;
	logic [32:0] ent_end;
	logic [33:0] te_round;

	function automatic result_t make_result(kind_t k, logic [ADDR_W-1:0] b,
			logic [ADDR_W-1:0] l, logic [WORD_W-1:0] t, logic [IDX_W-1:0] i,
			logic [TOTAL_W-1:0] tot);
		result_t r;
		r.kind   = k;
		r.base   = b;
		r.length = l;
		r.rtype  = t;
		r.index  = i;
		r.total  = tot;
		r.last   = 1'b0;
		return r;
	endfunction

	always_comb begin
		phase_d     = phase_q;
		pos_d       = pos_q;
		blob_size_d = blob_size_q;
		tag_end_d   = tag_end_q;
		stride_d    = stride_q;
		ent_start_d = ent_start_q;
		held_addr_d = held_addr_q;
		held_len_d  = held_len_q;
		regions_d   = regions_q;
		res_v[0]    = '0;
		res_v[1]    = '0;
		push_n      = 2'd0;
		w           = s1_word_s1;
		c_neg       = (pos_q < 32'd4);
		c_w         = {2'b00, pos_q} - 34'd4;
		size_a      = ({2'b00, w} + 34'(ALIGN_BYTES - 1)) & ~34'(ALIGN_BYTES - 1);
		if (size_a < 34'(HDR_BYTES)) begin
			size_a = 34'(HDR_BYTES);
		end
		map_end     = c_w + {2'b00, w};
		fin_req     = 1'b0;
		fin_ovf     = 1'b0;
		fin_next    = '0;
		ent_chk     = 1'b0;
		ent_end     = '0;
		te_round    = ({2'b00, tag_end_q} + 34'(ALIGN_BYTES - 1))
			& ~34'(ALIGN_BYTES - 1);

		if (s1_valid_s1) begin
			if (s1_first_s1) begin
				// size word of a new blob: restart in any phase
				blob_size_d = w;
				pos_d       = 32'd4;
				regions_d   = '0;
				if (w < 32'(2 * HDR_BYTES)) begin
					res_v[0] = make_result(KIND_BLOB_END, '0, '0, '0, '0, '0);
					push_n   = 2'd1;
					phase_d  = PH_IDLE;
				end else begin
					phase_d = PH_RSV;
				end
			end else if (phase_q != PH_IDLE) begin
				pos_d = pos_q + 32'd4;
				unique case (phase_q)
					PH_RSV: begin
						phase_d = PH_TYPE;
					end
					PH_TYPE: begin
						if (w == TAG_TYPE_END) begin
							res_v[0] = make_result(KIND_END_TAG, '0, '0, '0, '0, regions_q);
							push_n   = 2'd1;
							phase_d  = PH_IDLE;
						end else if (w == TAG_TYPE_MMAP) begin
							phase_d = PH_SIZE_MMAP;
						end else begin
							phase_d = PH_SIZE_OTHER;
						end
					end
					PH_SIZE_OTHER, PH_SIZE_MMAP: begin
						if (phase_q == PH_SIZE_MMAP && !c_neg
								&& w >= 32'(MMAP_HDR_BYTES + ENTRY_BYTES)
								&& c_w + 34'(MMAP_HDR_BYTES + ENTRY_BYTES)
									<= {2'b00, blob_size_q}
								&& regions_q < TOTAL_W'(REGION_LIMIT)) begin
							// map tag end, clipped to the blob
							if (map_end > {2'b00, blob_size_q}) begin
								tag_end_d = blob_size_q;
							end else begin
								tag_end_d = map_end[31:0];
							end
							phase_d = PH_STRIDE;
						end else begin
							fin_req  = 1'b1;
							fin_ovf  = c_neg;
							fin_next = {1'b0, c_w} + {1'b0, size_a};
						end
					end
					PH_STRIDE: begin
						stride_d = w;
						phase_d  = PH_VERSION;
					end
					PH_VERSION: begin
						ent_start_d = pos_d;
						ent_chk     = 1'b1;
					end
					PH_SKIP: begin
						if (pos_d >= tag_end_q) begin
							phase_d = PH_TYPE;
						end
					end
					PH_EPAD: begin
						if (pos_d >= ent_start_q) begin
							phase_d = PH_E0;
						end
					end
					PH_E0: begin
						held_addr_d = {32'd0, w};
						phase_d     = PH_E1;
					end
					PH_E1: begin
						held_addr_d[63:32] = w;
						phase_d            = PH_E2;
					end
					PH_E2: begin
						held_len_d = {32'd0, w};
						phase_d    = PH_E3;
					end
					PH_E3: begin
						held_len_d[63:32] = w;
						phase_d           = PH_E4;
					end
					PH_E4: begin
						if (held_len_q != '0) begin
							regions_d = regions_q + TOTAL_W'(1);
							res_v[0]  = make_result(KIND_REGION, held_addr_q, held_len_q, w,
								regions_q[IDX_W-1:0], regions_d);
							push_n    = 2'd1;
						end
						ent_start_d = ent_start_q + stride_q;
						ent_chk     = 1'b1;
					end
					default: begin
						phase_d = PH_IDLE;
					end
				endcase
			end
		end

		// next entry, or close the map tag
		if (ent_chk) begin
			ent_end = {1'b0, ent_start_d} + {1'b0, stride_q};
			if (stride_q >= 32'(ENTRY_BYTES) && stride_q[1:0] == 2'b00
					&& regions_d < TOTAL_W'(REGION_LIMIT)
					&& ent_end <= {1'b0, tag_end_q}) begin
				phase_d = (pos_d >= ent_start_d) ? PH_E0 : PH_EPAD;
			end else begin
				fin_req  = 1'b1;
				fin_next = {1'b0, te_round};
			end
		end

		// move to the following tag, or end when its header cannot fit
		if (fin_req) begin
			if (fin_ovf || fin_next + 35'(HDR_BYTES) > {3'b000, blob_size_d}) begin
				res_v[push_n[0]] = make_result(KIND_BLOB_END, '0, '0, '0, '0, regions_d);
				push_n           = push_n + 2'd1;
				phase_d          = PH_IDLE;
			end else begin
				tag_end_d = fin_next[31:0];
				phase_d   = (pos_d >= fin_next[31:0]) ? PH_TYPE : PH_SKIP;
			end
		end

		if (push_n == 2'd2) begin
			res_v[1].last = 1'b1;
		end else if (push_n == 2'd1) begin
			res_v[0].last = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			pos_q       <= '0;
			blob_size_q <= '0;
			tag_end_q   <= '0;
			stride_q    <= '0;
			ent_start_q <= '0;
			regions_q   <= '0;
		end else begin
			phase_q     <= phase_d;
			pos_q       <= pos_d;
			blob_size_q <= blob_size_d;
			tag_end_q   <= tag_end_d;
			stride_q    <= stride_d;
			ent_start_q <= ent_start_d;
			regions_q   <= regions_d;
		end
	end

	// entry words are always written before they are used
	always_ff @(posedge clk) begin
		held_addr_q <= held_addr_d;
		held_len_q  <= held_len_d;
	end

	// ---------------- output queue ----------------
	result_t             q_mem_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] q_wr_q, q_rd_q;
	logic                q_pop;
	result_t             head;

	assign q_pop        = result.valid && result.ready;
	assign head         = q_mem_q[q_rd_q];
	assign result.valid = (q_cnt_q != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_wr_q  <= '0;
			q_rd_q  <= '0;
			q_cnt_q <= '0;
		end else begin
			q_wr_q  <= q_wr_q + QUEUE_AW'(push_n);
			q_rd_q  <= q_rd_q + QUEUE_AW'(q_pop);
			q_cnt_q <= q_cnt_q + QUEUE_CW'(push_n) - QUEUE_CW'(q_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			q_mem_q[q_wr_q] <= res_v[0];
		end
		if (push_n == 2'd2) begin
			q_mem_q[q_wr_q + QUEUE_AW'(1)] <= res_v[1];
		end
	end

	assign result.result_kind   = head.kind;
	assign result.region_base   = head.base;
	assign result.region_length = head.length;
	assign result.region_type   = head.rtype;
	assign result.region_index  = head.index;
	assign result.region_total  = head.total;
	assign result.last_result   = head.last;

	// ---------------- checks ----------------
	`BIMP_ASSERT_IMPLY(a_queue_room, clk, arst_n, s1_valid_s1, q_cnt_q <= QUEUE_CW'(QUEUE_DEPTH - 2), "queue too full for a decoded word")
	`BIMP_ASSERT_IMPLY(a_pair_order, clk, arst_n, push_n == 2'd2, res_v[0].kind == KIND_REGION && res_v[1].kind == KIND_BLOB_END, "two records must be region then blob end")
	`BIMP_ASSERT_ALWAYS(a_region_cap, clk, arst_n, regions_q <= TOTAL_W'(REGION_LIMIT), "region count past limit")
	`BIMP_ASSERT_IMPLY(a_idle_quiet, clk, arst_n, s1_valid_s1 && !s1_first_s1 && phase_q == PH_IDLE, push_n == 2'd0, "record outside a blob")

endmodule
